// ----- rtl/assert_macros.svh -----
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds whenever reset is released.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lms_pkg.sv -----
// Types and constants for the LED matrix scan controller.
package lms_pkg;

    localparam int COLS          = 4;
    localparam int ROWS          = 16;
    localparam int GROUPS        = 3;
    localparam int ROW_CHAIN_LEN = 16;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int OP_W      = 2;
    localparam int ROW_W     = 4;
    localparam int BIT_W     = $clog2(DATA_W);
    localparam int CHAIN_W   = $clog2(ROW_CHAIN_LEN);
    localparam int COL_W     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int GRP_BYTES = ROWS * COLS;
    localparam int BUF_BYTES = GROUPS * GRP_BYTES;
    localparam int GRP_AW    = $clog2(GRP_BYTES);
    localparam int RAM_DEPTH = 2 * GRP_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWAP  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic chain;
        logic row_bit;
        logic col_bit_a;
        logic col_bit_b;
        logic col_bit_c;
        logic latch;
        logic last;
    } result_t;

    typedef logic [GROUPS-1:0][DATA_W-1:0] grp_bytes_t;

    typedef struct packed {
        logic              clear;
        logic [RAM_AW-1:0] clr_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              back_sel;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
        logic [COL_W-1:0]  rd_col;
        logic              front_sel;
    } fb_ctrl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } col_ctrl_t;

endpackage

// ----- rtl/lms_ram.sv -----
// Generic single-port-write, registered-read RAM.
module lms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lms_fbuf.sv -----
// Front and back frame buffers: one RAM per row group, write decode and scan reads.
module lms_fbuf (
    input  logic               aclk,
    input  lms_pkg::fb_ctrl_t  ctrl,
    output lms_pkg::grp_bytes_t rd_bytes
);

    logic [lms_pkg::GROUPS-1:0] grp_hit;
    logic [lms_pkg::GRP_AW-1:0] wr_off;
    logic [lms_pkg::RAM_AW-1:0] wr_ram_addr;
    logic [lms_pkg::RAM_AW-1:0] rd_idx;
    logic [lms_pkg::RAM_AW-1:0] rd_ram_addr;

    always_comb begin
        grp_hit = '0;
        wr_off  = lms_pkg::GRP_AW'(ctrl.wr_addr);
        if (ctrl.wr_addr < lms_pkg::ADDR_W'(lms_pkg::GRP_BYTES)) begin
            grp_hit[0] = 1'b1;
        end else if (ctrl.wr_addr < lms_pkg::ADDR_W'(2 * lms_pkg::GRP_BYTES)) begin
            grp_hit[1] = 1'b1;
            wr_off = lms_pkg::GRP_AW'(ctrl.wr_addr - lms_pkg::ADDR_W'(lms_pkg::GRP_BYTES));
        end else if (ctrl.wr_addr < lms_pkg::ADDR_W'(lms_pkg::BUF_BYTES)) begin
            grp_hit[2] = 1'b1;
            wr_off = lms_pkg::GRP_AW'(ctrl.wr_addr
                                      - lms_pkg::ADDR_W'(2 * lms_pkg::GRP_BYTES));
        end
    end

    assign wr_ram_addr = ctrl.back_sel
                       ? lms_pkg::RAM_AW'(wr_off) + lms_pkg::RAM_AW'(lms_pkg::GRP_BYTES)
                       : lms_pkg::RAM_AW'(wr_off);

    assign rd_idx = lms_pkg::RAM_AW'(lms_pkg::RAM_AW'(ctrl.rd_row)
                                     * lms_pkg::RAM_AW'(lms_pkg::COLS))
                  + lms_pkg::RAM_AW'(ctrl.rd_col);

    assign rd_ram_addr = ctrl.front_sel
                       ? rd_idx + lms_pkg::RAM_AW'(lms_pkg::GRP_BYTES)
                       : rd_idx;

    for (genvar gi = 0; gi < lms_pkg::GROUPS; gi++) begin : g_grp
        logic                        ram_we;
        logic [lms_pkg::RAM_AW-1:0]  ram_waddr;
        logic [lms_pkg::DATA_W-1:0]  ram_wdata;

        assign ram_we    = ctrl.clear | (ctrl.wr_en & grp_hit[gi]);
        assign ram_waddr = ctrl.clear ? ctrl.clr_addr : wr_ram_addr;
        assign ram_wdata = ctrl.clear ? '0 : ctrl.wr_data;

        lms_ram #(
            .WIDTH (lms_pkg::DATA_W),
            .DEPTH (lms_pkg::RAM_DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (ram_we),
            .wr_addr (ram_waddr),
            .wr_data (ram_wdata),
            .rd_en   (ctrl.rd_en),
            .rd_addr (rd_ram_addr),
            .rd_data (rd_bytes[gi])
        );
    end

endmodule

// ----- rtl/lms_colshift.sv -----
// Column shift registers: one byte per row group, shifted out MSB first.
module lms_colshift (
    input  logic                       aclk,
    input  lms_pkg::col_ctrl_t         ctrl,
    input  lms_pkg::grp_bytes_t        din,
    output logic [lms_pkg::GROUPS-1:0] col_bits
);

    lms_pkg::grp_bytes_t sh_reg;
    lms_pkg::grp_bytes_t sh_next;

    always_comb begin
        sh_next = sh_reg;
        if (ctrl.load) begin
            sh_next = din;
        end else if (ctrl.shift) begin
            for (int g = 0; g < lms_pkg::GROUPS; g++) begin
                sh_next[g] = {sh_reg[g][lms_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    for (genvar gi = 0; gi < lms_pkg::GROUPS; gi++) begin : g_bit
        assign col_bits[gi] = sh_reg[gi][lms_pkg::DATA_W-1];
    end

endmodule

// ----- rtl/led_matrix_scan_double_buffer.sv -----
// LED matrix scan controller top level with double-buffered frame store.
// Tick: 32 + 8*COLS shift steps (64 here), one per cycle while the receiver is not stalling.
// Write and swap transactions emit nothing; a tick emits all its steps before the next item is taken.
// Pace is set by the serial row and column shift chains, one bit per cycle when not stalled.
// Reset: clearing pass over all 2*ROWS*COLS (128) frame RAM addresses, no input taken meanwhile.
`include "assert_macros.svh"

module led_matrix_scan_double_buffer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lms_pkg::item_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lms_pkg::result_t m_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BLANK,
        ST_COLS,
        ST_SELECT
    } state_t;

    state_t                              state_reg, state_next;
    logic [lms_pkg::RAM_AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [lms_pkg::CHAIN_W-1:0]         step_cnt_reg, step_cnt_next;
    logic [lms_pkg::COL_W-1:0]           col_cnt_reg, col_cnt_next;
    logic [lms_pkg::BIT_W-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [lms_pkg::ROW_CHAIN_LEN-1:0]   row_sr_reg, row_sr_next;
    logic [lms_pkg::ROW_W-1:0]           scan_row_reg, scan_row_next;
    logic                                front_reg, front_next;
    logic                                swap_pending_reg, swap_pending_next;
    logic                                m_valid_reg, m_valid_next;
    lms_pkg::result_t                    m_data_reg, m_data_next;

    lms_pkg::fb_ctrl_t                   fb_ctrl;
    lms_pkg::col_ctrl_t                  col_ctrl;
    lms_pkg::grp_bytes_t                 rd_bytes;
    logic [lms_pkg::GROUPS-1:0]          col_bits;
    logic                                advance;
    logic [lms_pkg::ROW_W:0]             row_inc;

    lms_fbuf u_fbuf (
        .aclk     (aclk),
        .ctrl     (fb_ctrl),
        .rd_bytes (rd_bytes)
    );

    lms_colshift u_colshift (
        .aclk     (aclk),
        .ctrl     (col_ctrl),
        .din      (rd_bytes),
        .col_bits (col_bits)
    );

    assign advance = !m_valid_reg || m_ready;
    assign row_inc = {1'b0, scan_row_reg} + (lms_pkg::ROW_W + 1)'(1);

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        step_cnt_next     = step_cnt_reg;
        col_cnt_next      = col_cnt_reg;
        bit_cnt_next      = bit_cnt_reg;
        row_sr_next       = row_sr_reg;
        scan_row_next     = scan_row_reg;
        front_next        = front_reg;
        swap_pending_next = swap_pending_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        fb_ctrl.clear     = 1'b0;
        fb_ctrl.clr_addr  = clr_cnt_reg;
        fb_ctrl.wr_en     = 1'b0;
        fb_ctrl.wr_addr   = s_data.address;
        fb_ctrl.wr_data   = s_data.data;
        fb_ctrl.back_sel  = ~front_reg;
        fb_ctrl.rd_en     = 1'b0;
        fb_ctrl.rd_row    = scan_row_reg;
        fb_ctrl.rd_col    = lms_pkg::COL_W'(lms_pkg::COLS - 1);
        fb_ctrl.front_sel = front_reg;

        col_ctrl.load     = 1'b0;
        col_ctrl.shift    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                fb_ctrl.clear = 1'b1;
                clr_cnt_next  = clr_cnt_reg + lms_pkg::RAM_AW'(1);
                if (clr_cnt_reg == lms_pkg::RAM_AW'(lms_pkg::RAM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.operation)
                        lms_pkg::OP_TICK: begin
                            state_next    = ST_BLANK;
                            step_cnt_next = lms_pkg::CHAIN_W'(lms_pkg::ROW_CHAIN_LEN - 1);
                            row_sr_next   = '0;
                            fb_ctrl.rd_en = 1'b1;
                        end
                        lms_pkg::OP_WRITE: begin
                            fb_ctrl.wr_en = 1'b1;
                        end
                        lms_pkg::OP_SWAP: begin
                            swap_pending_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BLANK: begin
                if (advance) begin
                    m_valid_next           = 1'b1;
                    m_data_next.chain      = 1'b0;
                    m_data_next.row_bit    = row_sr_reg[lms_pkg::ROW_CHAIN_LEN-1];
                    m_data_next.col_bit_a  = 1'b1;
                    m_data_next.col_bit_b  = 1'b1;
                    m_data_next.col_bit_c  = 1'b1;
                    m_data_next.latch      = (step_cnt_reg == '0);
                    m_data_next.last       = 1'b0;
                    row_sr_next            = {row_sr_reg[lms_pkg::ROW_CHAIN_LEN-2:0], 1'b0};
                    step_cnt_next          = step_cnt_reg - lms_pkg::CHAIN_W'(1);
                    if (step_cnt_reg == '0) begin
                        state_next    = ST_COLS;
                        col_ctrl.load = 1'b1;
                        col_cnt_next  = lms_pkg::COL_W'(lms_pkg::COLS - 1);
                        bit_cnt_next  = lms_pkg::BIT_W'(lms_pkg::DATA_W - 1);
                        if (lms_pkg::COLS > 1) begin
                            fb_ctrl.rd_en  = 1'b1;
                            fb_ctrl.rd_col = lms_pkg::COL_W'(lms_pkg::COLS - 2);
                        end
                    end
                end
            end
            ST_COLS: begin
                if (advance) begin
                    m_valid_next           = 1'b1;
                    m_data_next.chain      = 1'b1;
                    m_data_next.row_bit    = 1'b0;
                    m_data_next.col_bit_a  = ~col_bits[0];
                    m_data_next.col_bit_b  = ~col_bits[1];
                    m_data_next.col_bit_c  = ~col_bits[2];
                    m_data_next.latch      = (col_cnt_reg == '0) && (bit_cnt_reg == '0);
                    m_data_next.last       = 1'b0;
                    if (bit_cnt_reg != '0) begin
                        col_ctrl.shift = 1'b1;
                        bit_cnt_next   = bit_cnt_reg - lms_pkg::BIT_W'(1);
                    end else if (col_cnt_reg != '0) begin
                        col_ctrl.load = 1'b1;
                        col_cnt_next  = col_cnt_reg - lms_pkg::COL_W'(1);
                        bit_cnt_next  = lms_pkg::BIT_W'(lms_pkg::DATA_W - 1);
                        if (col_cnt_reg > lms_pkg::COL_W'(1)) begin
                            fb_ctrl.rd_en  = 1'b1;
                            fb_ctrl.rd_col = col_cnt_reg - lms_pkg::COL_W'(2);
                        end
                    end else begin
                        state_next    = ST_SELECT;
                        step_cnt_next = lms_pkg::CHAIN_W'(lms_pkg::ROW_CHAIN_LEN - 1);
                        row_sr_next   = lms_pkg::ROW_CHAIN_LEN'(1) << scan_row_reg;
                    end
                end
            end
            ST_SELECT: begin
                if (advance) begin
                    m_valid_next           = 1'b1;
                    m_data_next.chain      = 1'b0;
                    m_data_next.row_bit    = row_sr_reg[lms_pkg::ROW_CHAIN_LEN-1];
                    m_data_next.col_bit_a  = 1'b1;
                    m_data_next.col_bit_b  = 1'b1;
                    m_data_next.col_bit_c  = 1'b1;
                    m_data_next.latch      = (step_cnt_reg == '0);
                    m_data_next.last       = (step_cnt_reg == '0);
                    row_sr_next            = {row_sr_reg[lms_pkg::ROW_CHAIN_LEN-2:0], 1'b0};
                    step_cnt_next          = step_cnt_reg - lms_pkg::CHAIN_W'(1);
                    if (step_cnt_reg == '0) begin
                        state_next = ST_IDLE;
                        if (row_inc >= (lms_pkg::ROW_W + 1)'(lms_pkg::ROWS)) begin
                            scan_row_next = '0;
                            if (swap_pending_reg) begin
                                swap_pending_next = 1'b0;
                                front_next        = ~front_reg;
                            end
                        end else begin
                            scan_row_next = lms_pkg::ROW_W'(row_inc);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            scan_row_reg     <= '0;
            front_reg        <= 1'b0;
            swap_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            scan_row_reg     <= scan_row_next;
            front_reg        <= front_next;
            swap_pending_reg <= swap_pending_next;
            m_valid_reg      <= m_valid_next;
        end
        step_cnt_reg <= step_cnt_next;
        col_cnt_reg  <= col_cnt_next;
        bit_cnt_reg  <= bit_cnt_next;
        row_sr_reg   <= row_sr_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPLIES(a_no_output_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !m_valid_reg)
    `ASSERT_IMPLIES(a_col_step_fields, aclk, aresetn, m_valid_reg && m_data_reg.chain,
                    !m_data_reg.row_bit && !m_data_reg.last)
    `ASSERT_IMPLIES(a_last_on_row_latch, aclk, aresetn, m_valid_reg && m_data_reg.last,
                    m_data_reg.latch && !m_data_reg.chain)
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for led_matrix_scan_double_buffer: predicts shift steps, checks results.
module tb;
    import lms_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int MAX_REPORTS     = 10;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    item_t   s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    led_matrix_scan_double_buffer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    logic [DATA_W-1:0] frame_bytes [2*BUF_BYTES] = '{default: '0};
    logic              front_buf   = 1'b0;
    logic              swap_armed  = 1'b0;
    logic [ROW_W-1:0]  scan_row_q  = '0;

    result_t steps_due[$];
    result_t want_step;
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    int      hold_seq       = 0;
    int      hold_seen      = 0;
    int      hold_left      = 0;
    int      idle_cycles    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic item_t make_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                        logic [DATA_W-1:0] data);
        item_t it;
        it.operation = op;
        it.address   = addr;
        it.data      = data;
        return it;
    endfunction

    function automatic result_t step_word(logic chain, logic row_bit, logic a, logic b,
                                          logic c, logic latch, logic last);
        result_t w;
        w.chain     = chain;
        w.row_bit   = row_bit;
        w.col_bit_a = a;
        w.col_bit_b = b;
        w.col_bit_c = c;
        w.latch     = latch;
        w.last      = last;
        return w;
    endfunction

    function automatic void push_row_pass(int sel, logic closing);
        for (int p = ROW_CHAIN_LEN - 1; p >= 0; p--) begin
            steps_due.push_back(step_word(1'b0, p == sel, 1'b1, 1'b1, 1'b1, p == 0,
                                          closing && p == 0));
        end
    endfunction

    function automatic void predict_scan(item_t it);
        int row;
        int idx;
        int back;
        logic [DATA_W-1:0] ga, gb, gc;
        back = front_buf ? 0 : BUF_BYTES;
        case (it.operation)
            OP_WRITE: begin
                if (it.address < BUF_BYTES) frame_bytes[back + it.address] = it.data;
            end
            OP_SWAP: begin
                swap_armed = 1'b1;
            end
            OP_TICK: begin
                row = (int'(scan_row_q) >= ROWS) ? ROWS - 1 : int'(scan_row_q);
                push_row_pass(-1, 1'b0);
                for (int x = COLS - 1; x >= 0; x--) begin
                    idx = (front_buf ? BUF_BYTES : 0) + row * COLS + x;
                    ga  = frame_bytes[idx];
                    gb  = frame_bytes[idx + GRP_BYTES];
                    gc  = frame_bytes[idx + 2 * GRP_BYTES];
                    for (int i = DATA_W - 1; i >= 0; i--) begin
                        steps_due.push_back(step_word(1'b1, 1'b0, ~ga[i], ~gb[i], ~gc[i],
                                                      x == 0 && i == 0, 1'b0));
                    end
                end
                push_row_pass(int'(scan_row_q), 1'b1);
                if (int'(scan_row_q) + 1 >= ROWS) begin
                    scan_row_q = '0;
                    if (swap_armed) begin
                        swap_armed = 1'b0;
                        front_buf  = ~front_buf;
                    end
                end else begin
                    scan_row_q = scan_row_q + 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_scan(it);
    endtask

    task automatic note_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t %s: expected %b actual %b (chain,row,a,b,c,latch,last)",
                     $time, what, want, got);
        end
    endtask

    // hold off for a counted stretch when asked, else stall at random
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_seen = hold_seq;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (steps_due.size() == 0) begin
                note_mismatch("unexpected transaction", '0, m_data);
            end else begin
                want_step = steps_due.pop_front();
                if (m_data.chain !== want_step.chain || m_data.row_bit !== want_step.row_bit ||
                    m_data.col_bit_a !== want_step.col_bit_a ||
                    m_data.col_bit_b !== want_step.col_bit_b ||
                    m_data.col_bit_c !== want_step.col_bit_c ||
                    m_data.latch !== want_step.latch || m_data.last !== want_step.last) begin
                    note_mismatch("mismatch", want_step, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic run_bursts(int n_items);
        int sent;
        int n_wr;
        int n_tk;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(11) == 0) begin
                send_item(make_item(OP_UNUSED, ADDR_W'($urandom), DATA_W'($urandom)));
            end
            n_wr = $urandom_range(6, 1);
            n_tk = $urandom_range(5, 1);
            repeat (n_wr) begin
                send_item(make_item(OP_WRITE,
                                    ($urandom_range(9) == 0) ?
                                        ADDR_W'($urandom_range(255, BUF_BYTES)) :
                                        ADDR_W'($urandom_range(BUF_BYTES - 1, 0)),
                                    DATA_W'($urandom)));
            end
            if ($urandom_range(2) == 0) begin
                send_item(make_item(OP_SWAP, ADDR_W'($urandom), DATA_W'($urandom)));
                sent++;
            end
            repeat (n_tk) begin
                send_item(make_item(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom)));
            end
            sent += n_wr + n_tk;
        end
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(make_item(OP_TICK, 8'h00, 8'h00));
        send_item(make_item(OP_UNUSED, 8'hFF, 8'hFF));
        send_item(make_item(OP_WRITE, 8'd0, 8'hFF));
        send_item(make_item(OP_WRITE, 8'd191, 8'h80));
        send_item(make_item(OP_WRITE, 8'd64, 8'h01));
        send_item(make_item(OP_WRITE, 8'd128, 8'hA5));
        send_item(make_item(OP_WRITE, 8'd192, 8'hFF));
        send_item(make_item(OP_WRITE, 8'd255, 8'h7E));
        send_item(make_item(OP_SWAP, 8'h00, 8'h00));
        send_item(make_item(OP_SWAP, 8'hFF, 8'hFF));
        repeat (ROWS) send_item(make_item(OP_TICK, 8'hFF, 8'hFF));
    endtask

    task automatic test_streaming();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_bursts(ITEMS_PER_PHASE);
    endtask

    task automatic test_fill_and_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_seq++;
        for (int k = 0; k < 24; k++) begin
            if (k % 3 == 2) begin
                send_item(make_item(OP_WRITE, ADDR_W'($urandom_range(BUF_BYTES - 1, 0)),
                                    DATA_W'($urandom)));
            end else begin
                send_item(make_item(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom)));
            end
        end
    endtask

    task automatic test_sender_gaps();
        src_idle_pct   = 58;
        sink_stall_pct = 0;
        run_bursts(ITEMS_PER_PHASE);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct   = 0;
        sink_stall_pct = 58;
        run_bursts(ITEMS_PER_PHASE);
    endtask

    task automatic test_both_idle();
        src_idle_pct   = 34;
        sink_stall_pct = 34;
        run_bursts(ITEMS_PER_PHASE);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_streaming();
        test_fill_and_stall();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        s_valid        <= 1'b0;
        sink_stall_pct = 0;
        while (steps_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && steps_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
